// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// depends on nothing; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define TLVD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define TLVD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/tlvd_pkg.sv
// shared types for the tlv stream deframer
// no dependencies; used by the channel interfaces and the top level
package tlvd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] msg_kind_type;
   typedef logic [31:0] length_type;

   // number of header bytes in each header field
   localparam length_type TYPE_BYTES   = 32'd2;
   localparam length_type LENGTH_BYTES = 32'd4;

   typedef enum logic [1:0] {
      PH_TYPE   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_VALUE  = 2'd2,
      PH_SPARE  = 2'd3
   } phase_type;

   // what one input byte produces
   typedef struct packed {
      logic     emit;
      byte_type value_byte;
      logic     has_value;
      logic     last;
   } emit_type;

endpackage

// File: rtl/tlvd_if.sv
// valid/ready channel interfaces for the byte input and the result output
// depends on tlvd_pkg for payload types
interface tlvd_req_if;
   logic               valid;
   logic               ready;
   tlvd_pkg::byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface tlvd_rsp_if;
   logic                   valid;
   logic                   ready;
   tlvd_pkg::msg_kind_type msg_type;
   tlvd_pkg::length_type   msg_length;
   tlvd_pkg::byte_type     value_byte;
   logic                   has_value;
   logic                   last;

   modport source (output valid, output msg_type, output msg_length, output value_byte,
                   output has_value, output last, input ready);
   modport sink   (input valid, input msg_type, input msg_length, input value_byte,
                   input has_value, input last, output ready);
endinterface

// File: rtl/tlv_stream_deframer.sv
// tlv stream deframer top level
// depends on tlvd_pkg, tlvd_if.sv and assert_macros.svh
//
// usage:
//   req carries one stream byte per item (data_byte). each message is a
//   big-endian 16-bit type, a big-endian 32-bit length, then length value bytes.
//   rsp carries one item per value byte with msg_type, msg_length, the byte,
//   has_value = 1 and last set on the final byte. a zero-length message gives a
//   single item with has_value = 0, value_byte = 0 and last = 1 when its fourth
//   length byte arrives. header bytes give no item.
//   each accepted byte is held in the input register, and its result is then
//   held in the result register, whose contents drive the rsp channel.
//   throughput: one byte per cycle while rsp is not stalled. the parse step
//   shifts the header registers and bumps the 32-bit byte counter.
//   reset (synchronous, active high) empties both registers and returns the
//   parser to the type field. when rsp stalls, the waiting result holds and the
//   input register still drains bytes that give no result; req.ready falls only
//   once a result-producing byte waits behind the stalled result.
`include "assert_macros.svh"

module tlv_stream_deframer (
   input  logic        clock,
   input  logic        reset,
   tlvd_req_if.sink    req,
   tlvd_rsp_if.source  rsp
);

   // input register
   logic               in_valid_ff, in_valid_in;
   tlvd_pkg::byte_type in_byte_ff;

   // parser state
   tlvd_pkg::phase_type    phase_ff, phase_in;
   tlvd_pkg::length_type   byte_count_ff, byte_count_in;
   tlvd_pkg::msg_kind_type type_shift_ff, type_shift_in;
   tlvd_pkg::length_type   length_shift_ff, length_shift_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   tlvd_pkg::msg_kind_type out_type_ff;
   tlvd_pkg::length_type   out_length_ff;
   tlvd_pkg::byte_type     out_byte_ff;
   logic                   out_has_value_ff;
   logic                   out_last_ff;

   tlvd_pkg::emit_type     step;
   tlvd_pkg::length_type   count_inc;
   tlvd_pkg::length_type   new_length;
   logic                   value_done;
   logic                   in_advance;

   assign count_inc  = byte_count_ff + 32'd1;
   assign new_length = {length_shift_ff[23:0], in_byte_ff};
   assign value_done = (count_inc >= length_shift_ff);

   // bytes that give no result always move on; a result needs a free output slot
   assign in_advance = in_valid_ff && (!step.emit || !out_valid_ff || rsp.ready);
   assign req.ready  = !in_valid_ff || in_advance;

   // next state
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      type_shift_in   = type_shift_ff;
      length_shift_in = length_shift_ff;
      case (phase_ff)
         tlvd_pkg::PH_LENGTH: begin
            length_shift_in = new_length;
            if (count_inc >= tlvd_pkg::LENGTH_BYTES) begin
               byte_count_in = '0;
               phase_in = (new_length == '0) ? tlvd_pkg::PH_TYPE : tlvd_pkg::PH_VALUE;
            end else begin
               byte_count_in = count_inc;
            end
         end
         tlvd_pkg::PH_VALUE: begin
            if (value_done) begin
               byte_count_in = '0;
               phase_in      = tlvd_pkg::PH_TYPE;
            end else begin
               byte_count_in = count_inc;
            end
         end
         default: begin
            // type field; the spare code acts the same
            type_shift_in = {type_shift_ff[7:0], in_byte_ff};
            if (count_inc >= tlvd_pkg::TYPE_BYTES) begin
               byte_count_in = '0;
               phase_in      = tlvd_pkg::PH_LENGTH;
            end else begin
               byte_count_in = count_inc;
               phase_in      = tlvd_pkg::PH_TYPE;
            end
         end
      endcase
   end

   // result of the byte in the input register
   always_comb begin
      step = '0;
      case (phase_ff)
         tlvd_pkg::PH_LENGTH: begin
            // empty message
            if (count_inc >= tlvd_pkg::LENGTH_BYTES && new_length == '0) begin
               step.emit = 1'b1;
               step.last = 1'b1;
            end
         end
         tlvd_pkg::PH_VALUE: begin
            step.emit       = 1'b1;
            step.value_byte = in_byte_ff;
            step.has_value  = 1'b1;
            step.last       = value_done;
         end
         default: begin
            step = '0;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
      end
      out_valid_in = out_valid_ff;
      if (in_advance && step.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         phase_ff        <= tlvd_pkg::PH_TYPE;
         byte_count_ff   <= '0;
         type_shift_ff   <= '0;
         length_shift_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_advance) begin
            phase_ff        <= phase_in;
            byte_count_ff   <= byte_count_in;
            type_shift_ff   <= type_shift_in;
            length_shift_ff <= length_shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         in_byte_ff <= req.data_byte;
      end
      if (in_advance && step.emit) begin
         out_type_ff      <= type_shift_ff;
         out_length_ff    <= (phase_ff == tlvd_pkg::PH_LENGTH) ? new_length : length_shift_ff;
         out_byte_ff      <= step.value_byte;
         out_has_value_ff <= step.has_value;
         out_last_ff      <= step.last;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.msg_type   = out_type_ff;
   assign rsp.msg_length = out_length_ff;
   assign rsp.value_byte = out_byte_ff;
   assign rsp.has_value  = out_has_value_ff;
   assign rsp.last       = out_last_ff;

   `TLVD_ASSERT(a_empty_is_last, clock, reset, out_valid_ff && !out_has_value_ff |-> out_last_ff, "empty message result without last")
   `TLVD_ASSERT_NEVER(a_value_len_zero, clock, reset, phase_ff == tlvd_pkg::PH_VALUE && length_shift_ff == '0, "value phase with zero length")
   `TLVD_ASSERT_NEVER(a_type_count, clock, reset, phase_ff == tlvd_pkg::PH_TYPE && byte_count_ff >= tlvd_pkg::TYPE_BYTES, "type byte count overrun")
   `TLVD_ASSERT(a_last_returns, clock, reset, in_advance && phase_ff == tlvd_pkg::PH_VALUE && value_done |=> phase_ff == tlvd_pkg::PH_TYPE && byte_count_ff == '0, "final value byte did not restart parsing")

endmodule
